/* design/sacs_pkg.sv */
// Package for the suffix automaton common-substring block.
// Holds field widths, mode codes, default sizes and the result word type.
// No dependencies.
package sacs_pkg;

  localparam int MaxTextDef = 1024;
  localparam int AlphabetDef = 26;

  localparam int ModeW = 2;
  localparam int SymW = 5;
  localparam int LenOutW = 11;
  localparam int CntOutW = 12;

  localparam logic [ModeW-1:0] MODE_APPEND  = 2'd0;
  localparam logic [ModeW-1:0] MODE_MATCH   = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR   = 2'd2;
  localparam logic [ModeW-1:0] MODE_RESTART = 2'd3;

  typedef struct packed {
    logic [LenOutW-1:0] match_length;
    logic [LenOutW-1:0] best_length;
    logic [CntOutW-1:0] node_count;
    logic               overflow;
  } sacs_res_t;

endpackage

/* design/sacs_if.sv */
// Handshake channels of the suffix automaton block: input word and result word.
// Depends on sacs_pkg.
interface sacs_in_if import sacs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [SymW-1:0]  symbol;
  modport source (output valid, output mode, output symbol, input ready);
  modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface sacs_out_if import sacs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LenOutW-1:0] match_length;
  logic [LenOutW-1:0] best_length;
  logic [CntOutW-1:0] node_count;
  logic               overflow;
  modport source (output valid, output match_length, output best_length,
                  output node_count, output overflow, input ready);
  modport sink (input valid, input match_length, input best_length,
                input node_count, input overflow, output ready);
endinterface

/* design/sacs_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sacs_ram #(
  parameter int AddrW = 8,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/sacs_core.sv */
// Sequencer of the suffix automaton: builds nodes, walks links, matches.
// Depends on sacs_pkg and sacs_ram (transition, length and link stores).
module sacs_core import sacs_pkg::*; #(
  parameter int MaxText = MaxTextDef,
  parameter int Alphabet = AlphabetDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [SymW-1:0]  symbol_i,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output sacs_res_t        res_o
);
  localparam int NodeW = $clog2(2 * MaxText);
  localparam int LenW  = $clog2(MaxText + 1);
  localparam int AsymW = (Alphabet > 1) ? $clog2(Alphabet) : 1;
  localparam int NxtAw = NodeW + AsymW;
  localparam logic [NodeW-1:0] Root = NodeW'(1);
  localparam logic [AsymW-1:0] KLast = AsymW'(Alphabet - 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_AZ   = 5'd2,
                         S_ALEN = 5'd3,  S_ALNW = 5'd4,  S_W1   = 5'd5,
                         S_W1D  = 5'd6,  S_W1L  = 5'd7,  S_CLP  = 5'd8,
                         S_CLQ  = 5'd9,  S_CPY  = 5'd10, S_CPYE = 5'd11,
                         S_CLK  = 5'd12, S_CLK2 = 5'd13, S_CLK3 = 5'd14,
                         S_W2   = 5'd15, S_W2D  = 5'd16, S_W2L  = 5'd17,
                         S_MRD  = 5'd18, S_MCK  = 5'd19, S_MLN  = 5'd20,
                         S_MLK  = 5'd21, S_FIN  = 5'd22;

  logic [4:0]       st_q, st_d;
  logic [AsymW-1:0] sym_q, sym_d, k_q, k_d;
  logic [NodeW-1:0] p_q, p_d, qn_q, qn_d, fresh_q, fresh_d, clone_q, clone_d;
  logic [NodeW-1:0] tmp_q, tmp_d, last_q, last_d, used_q, used_d, mnode_q, mnode_d;
  logic [LenW-1:0]  lp_q, lp_d, mlen_q, mlen_d, best_q, best_d, tlen_q, tlen_d;
  logic             first_q, first_d, ovf_q, ovf_d, clr_rsp_q, clr_rsp_d;

  logic             nx_we, ln_we, lk_we;
  logic [NxtAw-1:0] nx_wa, nx_ra;
  logic [NodeW-1:0] nx_wd, nx_rd, ln_wa, ln_ra, lk_wa, lk_wd, lk_ra, lk_rd;
  logic [LenW-1:0]  ln_wd, ln_rd;
  logic [LenW-1:0]  best_nx;
  logic             sym_ok;

  sacs_ram #(.AddrW(NxtAw), .DataW(NodeW)) u_nxt (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(nx_ra), .rdata_o(nx_rd));
  sacs_ram #(.AddrW(NodeW), .DataW(LenW)) u_len (
    .clk_i, .we_i(ln_we), .waddr_i(ln_wa), .wdata_i(ln_wd),
    .raddr_i(ln_ra), .rdata_o(ln_rd));
  sacs_ram #(.AddrW(NodeW), .DataW(NodeW)) u_lnk (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd),
    .raddr_i(lk_ra), .rdata_o(lk_rd));

  assign sym_ok = int'(symbol_i) < Alphabet;
  assign best_nx = (mlen_q > best_q) ? mlen_q : best_q;
  assign in_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d = st_q; sym_d = sym_q; k_d = k_q; p_d = p_q; qn_d = qn_q;
    fresh_d = fresh_q; clone_d = clone_q; tmp_d = tmp_q; last_d = last_q;
    used_d = used_q; mnode_d = mnode_q; lp_d = lp_q; mlen_d = mlen_q;
    best_d = best_q; tlen_d = tlen_q; first_d = first_q; ovf_d = ovf_q;
    clr_rsp_d = clr_rsp_q;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
    res_valid_o = 1'b0;
    res_o = '{match_length: LenOutW'(mlen_q), best_length: LenOutW'(best_nx),
              node_count: CntOutW'(used_q), overflow: ovf_q};
    unique case (st_q)
      S_CLR: begin
        nx_we = 1'b1; nx_wa = {Root, k_q};
        ln_we = 1'b1; ln_wa = Root;
        lk_we = 1'b1; lk_wa = Root;
        k_d = k_q + 1'b1;
        if (k_q == KLast) st_d = clr_rsp_q ? S_FIN : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d = AsymW'(symbol_i);
          ovf_d = 1'b0;
          unique case (mode_i)
            MODE_APPEND: begin
              if (tlen_q >= LenW'(MaxText)) begin
                ovf_d = 1'b1; st_d = S_FIN;
              end else if (!sym_ok) begin
                st_d = S_FIN;
              end else begin
                p_d = last_q; fresh_d = used_q + 1'b1; used_d = used_q + 1'b1;
                last_d = used_q + 1'b1; tlen_d = tlen_q + 1'b1; k_d = '0;
                st_d = S_AZ;
              end
            end
            MODE_MATCH: begin
              if (!sym_ok) begin
                mnode_d = Root; mlen_d = '0; st_d = S_FIN;
              end else begin
                p_d = mnode_q; first_d = 1'b1; st_d = S_MRD;
              end
            end
            MODE_CLEAR: begin
              last_d = Root; used_d = Root; tlen_d = '0; mnode_d = Root;
              mlen_d = '0; best_d = '0; k_d = '0; clr_rsp_d = 1'b1; st_d = S_CLR;
            end
            MODE_RESTART: begin
              mnode_d = Root; mlen_d = '0; best_d = '0; st_d = S_FIN;
            end
            default: st_d = S_FIN;
          endcase
        end
      end
      S_AZ: begin
        nx_we = 1'b1; nx_wa = {fresh_q, k_q};
        k_d = k_q + 1'b1;
        if (k_q == KLast) st_d = S_ALEN;
      end
      S_ALEN: begin
        ln_ra = p_q; st_d = S_ALNW;
      end
      S_ALNW: begin
        ln_we = 1'b1; ln_wa = fresh_q; ln_wd = ln_rd + 1'b1; st_d = S_W1;
      end
      S_W1: begin
        if (p_q == '0) begin
          lk_we = 1'b1; lk_wa = fresh_q; lk_wd = Root; st_d = S_FIN;
        end else begin
          nx_ra = {p_q, sym_q}; st_d = S_W1D;
        end
      end
      S_W1D: begin
        if (nx_rd == '0) begin
          nx_we = 1'b1; nx_wa = {p_q, sym_q}; nx_wd = fresh_q;
          lk_ra = p_q; st_d = S_W1L;
        end else begin
          qn_d = nx_rd; ln_ra = p_q; st_d = S_CLP;
        end
      end
      S_W1L: begin
        p_d = lk_rd; st_d = S_W1;
      end
      S_CLP: begin
        lp_d = ln_rd; ln_ra = qn_q; st_d = S_CLQ;
      end
      S_CLQ: begin
        if ({1'b0, lp_q} + 1'b1 == {1'b0, ln_rd}) begin
          lk_we = 1'b1; lk_wa = fresh_q; lk_wd = qn_q; st_d = S_FIN;
        end else begin
          clone_d = used_q + 1'b1; used_d = used_q + 1'b1;
          ln_we = 1'b1; ln_wa = used_q + 1'b1; ln_wd = lp_q + 1'b1;
          k_d = '0; st_d = S_CPY;
        end
      end
      S_CPY: begin
        // read column k of q while writing column k-1 of the clone
        nx_ra = {qn_q, k_q};
        if (k_q != '0) begin
          nx_we = 1'b1; nx_wa = {clone_q, k_q - 1'b1}; nx_wd = nx_rd;
        end
        k_d = k_q + 1'b1;
        if (k_q == KLast) st_d = S_CPYE;
      end
      S_CPYE: begin
        nx_we = 1'b1; nx_wa = {clone_q, KLast}; nx_wd = nx_rd;
        lk_ra = qn_q; st_d = S_CLK;
      end
      S_CLK: begin
        lk_we = 1'b1; lk_wa = clone_q; lk_wd = lk_rd; st_d = S_CLK2;
      end
      S_CLK2: begin
        lk_we = 1'b1; lk_wa = qn_q; lk_wd = clone_q; st_d = S_CLK3;
      end
      S_CLK3: begin
        lk_we = 1'b1; lk_wa = fresh_q; lk_wd = clone_q; st_d = S_W2;
      end
      S_W2: begin
        if (p_q == '0) st_d = S_FIN;
        else begin
          nx_ra = {p_q, sym_q}; st_d = S_W2D;
        end
      end
      S_W2D: begin
        if (nx_rd == qn_q) begin
          nx_we = 1'b1; nx_wa = {p_q, sym_q}; nx_wd = clone_q;
          lk_ra = p_q; st_d = S_W2L;
        end else begin
          st_d = S_FIN;
        end
      end
      S_W2L: begin
        p_d = lk_rd; st_d = S_W2;
      end
      S_MRD: begin
        if (p_q == '0) begin
          mnode_d = Root; mlen_d = '0; st_d = S_FIN;
        end else begin
          nx_ra = {p_q, sym_q}; st_d = S_MCK;
        end
      end
      S_MCK: begin
        if (nx_rd != '0) begin
          if (first_q) begin
            mnode_d = nx_rd; mlen_d = mlen_q + 1'b1; st_d = S_FIN;
          end else begin
            tmp_d = nx_rd; ln_ra = p_q; st_d = S_MLN;
          end
        end else begin
          lk_ra = p_q; st_d = S_MLK;
        end
      end
      S_MLN: begin
        mlen_d = ln_rd + 1'b1; mnode_d = tmp_q; st_d = S_FIN;
      end
      S_MLK: begin
        p_d = lk_rd; first_d = 1'b0; st_d = S_MRD;
      end
      S_FIN: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1; best_d = best_nx; clr_rsp_d = 1'b0; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; k_q <= '0; last_q <= Root; used_q <= Root; tlen_q <= '0;
      mnode_q <= Root; mlen_q <= '0; best_q <= '0; ovf_q <= 1'b0;
      clr_rsp_q <= 1'b0; first_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; last_q <= last_d; used_q <= used_d;
      tlen_q <= tlen_d; mnode_q <= mnode_d; mlen_q <= mlen_d; best_q <= best_d;
      ovf_q <= ovf_d; clr_rsp_q <= clr_rsp_d; first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; p_q <= p_d; qn_q <= qn_d; fresh_q <= fresh_d;
    clone_q <= clone_d; tmp_q <= tmp_d; lp_q <= lp_d;
  end
endmodule

/* design/suffix_automaton_common_substring.sv */
// Top level of the suffix automaton longest-common-substring block.
// Depends on sacs_pkg, sacs_if and sacs_core.
//
// Usage: one input channel (in_i) carries words of {mode, symbol}; one output
// channel (out_o) returns exactly one result word per input word with the
// current match length, the best length since restart or clear, the node count
// and an overflow flag for a dropped text append.
// Modes: append text symbol, match pattern symbol, clear automaton, restart.
// A clear rewrites the root row column by column. Restart, dropped append
// and out-of-alphabet symbol go straight to the result. An append zeroes
// the new row column by column, writes its length and walks suffix links;
// on a clone it copies the row, sets the links and redirects transitions
// along further links. A match follows suffix links until a transition
// exists, then reads the node length. The work is set by the single read
// port of each node store, used once per step, and by the 26-column row
// zero and row copy. The core works on one word at a time; in_i.ready is
// high only when idle. Reset: rst_ni low clears all control state; the root
// row is then rewritten column by column, during which in_i.ready stays low.
// Stall: the result sits in an output register; a new word is accepted while
// it waits, but its own result is held until the register drains.
module suffix_automaton_common_substring import sacs_pkg::*; #(
  parameter int MaxText = MaxTextDef,
  parameter int Alphabet = AlphabetDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sacs_in_if.sink           in_i,
  sacs_out_if.source        out_o
);
  logic      res_valid, res_ready;
  sacs_res_t res;
  logic      out_valid_q;
  sacs_res_t out_q;

  sacs_core #(.MaxText(MaxText), .Alphabet(Alphabet)) u_core (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .mode_i(in_i.mode), .symbol_i(in_i.symbol),
    .res_ready_i(res_ready), .res_valid_o(res_valid), .res_o(res));

  // output register frees the core as soon as the word is latched
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.match_length = out_q.match_length;
  assign out_o.best_length  = out_q.best_length;
  assign out_o.node_count   = out_q.node_count;
  assign out_o.overflow     = out_q.overflow;
endmodule

/* design/sacs_chk.sv */
// Port-level checker for the suffix automaton block, bound to the top level.
// Depends on sacs_pkg and suffix_automaton_common_substring.
module sacs_chk import sacs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [LenOutW-1:0] match_length_i,
  input logic [LenOutW-1:0] best_length_i,
  input logic [CntOutW-1:0] node_count_i
);
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a word while busy");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("ready during root clear");

  a_best_ge_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (best_length_i >= match_length_i) && (node_count_i != '0))
    else $error("best below current match or empty automaton");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(best_length_i))
    else $error("result dropped under stall");
endmodule

bind suffix_automaton_common_substring sacs_chk u_sacs_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .match_length_i(out_o.match_length), .best_length_i(out_o.best_length),
  .node_count_i(out_o.node_count));

/* dv/tb_suffix_automaton_common_substring.sv */
// Testbench for the suffix automaton common-substring block.
// Depends on sacs_pkg, sacs_if and the suffix_automaton_common_substring RTL.
module tb_suffix_automaton_common_substring;
  import sacs_pkg::*;

  localparam int MaxText = MaxTextDef;
  localparam int Alpha = AlphabetDef;
  localparam int NodeSlots = 2 * MaxText;
  localparam int Root = 1;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [SymW-1:0]  symbol;
  } sym_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sacs_in_if  in_if ();
  sacs_out_if out_if ();

  suffix_automaton_common_substring u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow automaton.
  int unsigned sa_next [NodeSlots+2][Alpha];
  int unsigned sa_len [NodeSlots+2];
  int unsigned sa_link [NodeSlots+2];
  int unsigned sa_last, sa_used, sa_text, m_node, m_len, m_best;

  sym_word_t pending_words[$];
  sacs_res_t expected_results[$];
  int unsigned n_errors = 0;
  bit rx_hold = 0;     // long receiver hold-off requested
  bit tx_pause = 0;    // sender waits until drained

  // handshakes seen at the last rising edge
  bit in_taken = 0;
  bit out_taken = 0;

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    out_taken <= rst_ni && out_if.valid && out_if.ready;
  end

  function automatic void sa_clear();
    for (int n = 0; n < NodeSlots + 2; n++) begin
      sa_len[n] = 0;
      sa_link[n] = 0;
      for (int c = 0; c < Alpha; c++) sa_next[n][c] = 0;
    end
    sa_last = Root; sa_used = 1; sa_text = 0;
    m_node = Root; m_len = 0; m_best = 0;
  endfunction

  function automatic void sa_extend(int unsigned c);
    int unsigned p, fresh, q, cl;
    p = sa_last;
    sa_used++;
    fresh = sa_used;
    for (int k = 0; k < Alpha; k++) sa_next[fresh][k] = 0;
    sa_len[fresh] = sa_len[p] + 1;
    sa_link[fresh] = 0;
    sa_last = fresh;
    while (p != 0 && sa_next[p][c] == 0) begin
      sa_next[p][c] = fresh;
      p = sa_link[p];
    end
    if (p == 0) begin
      sa_link[fresh] = Root;
      return;
    end
    q = sa_next[p][c];
    if (sa_len[p] + 1 == sa_len[q]) begin
      sa_link[fresh] = q;
      return;
    end
    sa_used++;
    cl = sa_used;
    sa_len[cl] = sa_len[p] + 1;
    for (int k = 0; k < Alpha; k++) sa_next[cl][k] = sa_next[q][k];
    sa_link[cl] = sa_link[q];
    sa_link[q] = cl;
    sa_link[fresh] = cl;
    while (p != 0 && sa_next[p][c] == q) begin
      sa_next[p][c] = cl;
      p = sa_link[p];
    end
  endfunction

  function automatic void sa_feed(int unsigned s);
    int unsigned cur;
    cur = m_node;
    if (s >= Alpha) begin
      m_node = Root; m_len = 0;
      return;
    end
    if (sa_next[cur][s] != 0) begin
      m_node = sa_next[cur][s];
      m_len++;
    end else begin
      while (cur != 0 && sa_next[cur][s] == 0) cur = sa_link[cur];
      if (cur != 0) begin
        m_len = sa_len[cur] + 1;
        m_node = sa_next[cur][s];
      end else begin
        m_node = Root; m_len = 0;
      end
    end
    if (m_len > m_best) m_best = m_len;
  endfunction

  function automatic sacs_res_t sa_step(sym_word_t w);
    sacs_res_t r;
    r.overflow = 1'b0;
    case (w.mode)
      MODE_APPEND: begin
        if (sa_text >= MaxText) r.overflow = 1'b1;
        else if (w.symbol < Alpha) begin
          sa_extend(w.symbol);
          sa_text++;
        end
      end
      MODE_MATCH: sa_feed(w.symbol);
      MODE_CLEAR: sa_clear();
      default: begin
        m_node = Root; m_len = 0; m_best = 0;
      end
    endcase
    r.match_length = m_len[LenOutW-1:0];
    r.best_length = m_best[LenOutW-1:0];
    r.node_count = sa_used[CntOutW-1:0];
    return r;
  endfunction

  // Driver: random gap per word, changes on the falling edge.
  int unsigned tx_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode <= '0;
      in_if.symbol <= '0;
      tx_gap <= 0;
    end else begin
      if (in_taken) begin
        // word taken at the last rising edge
        expected_results.push_back(sa_step({in_if.mode, in_if.symbol}));
        void'(pending_words.pop_front());
        tx_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        in_if.valid <= 1'b0;
      end else if (!in_if.valid && tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (!in_if.valid && pending_words.size() > 0 &&
                   !(tx_pause && expected_results.size() > 0)) begin
        in_if.valid <= 1'b1;
        in_if.mode <= pending_words[0].mode;
        in_if.symbol <= pending_words[0].symbol;
      end
    end
  end

  // Monitor: sampled at the rising edge, ready changed at the falling edge.
  int unsigned rx_gap = 0;
  always @(posedge clk_i) begin
    sacs_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.match_length !== want.match_length) begin
          $error("match_length expected %0d got %0d", want.match_length,
                 out_if.match_length);
          n_errors++;
        end
        if (out_if.best_length !== want.best_length) begin
          $error("best_length expected %0d got %0d", want.best_length,
                 out_if.best_length);
          n_errors++;
        end
        if (out_if.node_count !== want.node_count) begin
          $error("node_count expected %0d got %0d", want.node_count,
                 out_if.node_count);
          n_errors++;
        end
        if (out_if.overflow !== want.overflow) begin
          $error("overflow expected %0d got %0d", want.overflow, out_if.overflow);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_hold) begin
      out_if.ready <= 1'b0;
    end else if (out_taken) begin
      // one draw per word
      if ($urandom_range(0, 3) == 0) out_if.ready <= 1'b1;
      else begin
        out_if.ready <= 1'b0;
        rx_gap <= $urandom_range(0, 18);
      end
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic put(logic [ModeW-1:0] m, int unsigned s);
    sym_word_t w;
    w.mode = m;
    w.symbol = s[SymW-1:0];
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  // Text from the first 2 to Alpha symbols, so small spans make repeats and clones frequent.
  task automatic random_round(int unsigned n_text, int unsigned n_pat);
    int unsigned span;
    span = $urandom_range(2, Alpha);
    for (int i = 0; i < n_text; i++) put(MODE_APPEND, $urandom_range(0, span - 1));
    for (int i = 0; i < n_pat; i++) begin
      case ($urandom_range(0, 19))
        0: put(MODE_RESTART, $urandom_range(0, 31));
        1: put(MODE_MATCH, $urandom_range(0, 31));
        2: put(MODE_APPEND, $urandom_range(0, 31));
        default: put(MODE_MATCH, $urandom_range(0, span - 1));
      endcase
    end
  endtask

  int unsigned n_items;
  initial begin
    sa_clear();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: repeats that force clones, matching, out-of-range symbols.
    put(MODE_MATCH, 0);            // empty automaton
    put(MODE_APPEND, 0); put(MODE_APPEND, 1); put(MODE_APPEND, 0);
    put(MODE_APPEND, 1); put(MODE_APPEND, 1);   // abab b: clone
    put(MODE_APPEND, 25); put(MODE_APPEND, 31); // 25 is in the alphabet; 31 is beyond it and ignored
    put(MODE_APPEND, 26);
    put(MODE_MATCH, 0); put(MODE_MATCH, 1); put(MODE_MATCH, 1);
    put(MODE_MATCH, 2);            // mismatch to root
    put(MODE_MATCH, 1); put(MODE_MATCH, 31);   // out of alphabet
    put(MODE_MATCH, 25); put(MODE_MATCH, 26);
    put(MODE_RESTART, 0); put(MODE_MATCH, 0);
    put(MODE_CLEAR, 0); put(MODE_MATCH, 0); put(MODE_APPEND, 30);
    wait_drained();

    // Receiver holds off while the sender keeps offering.
    rx_hold = 1;
    random_round(4, 6);
    repeat (400) @(posedge clk_i);
    rx_hold = 0;
    wait_drained();

    // Fill the text to capacity, then overflow appends.
    put(MODE_CLEAR, 0);
    for (int i = 0; i < MaxText; i++) put(MODE_APPEND, $urandom_range(0, 2));
    for (int i = 0; i < 6; i++) put(MODE_APPEND, $urandom_range(0, 31));
    for (int i = 0; i < 20; i++) put(MODE_MATCH, $urandom_range(0, 3));
    wait_drained();

    n_items = 0;
    while (n_items < 650) begin
      int unsigned nt, np;
      nt = $urandom_range(1, 40);
      np = $urandom_range(1, 30);
      put(MODE_CLEAR, $urandom_range(0, 31));
      random_round(nt, np);
      n_items += nt + np + 1;
      if ($urandom_range(0, 4) == 0) begin
        tx_pause = 1;
        wait_drained();
        tx_pause = 0;
      end
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
